// ===== src/bsnp_pkg.sv =====
// Package for the box set nearest point clamp block.
// Holds shared widths, default parameter values, codes and the control state type.
// No dependencies.
package bsnp_pkg;

	// Default sizing of the block.
	localparam int DEF_MAX_BOXES  = 16;
	localparam int DEF_COORD_BITS = 24;

	// Fixed field widths.
	localparam int OP_W        = 1;
	localparam int SLOT_W      = 4;
	localparam int BOX_INDEX_W = 4;
	localparam int CFG_W       = 5;

	// Configuration port.
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic [APB_ADDR_W-1:0] ADDR_ACTIVE_BOX_COUNT = 3'd0;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_LOAD  = 1'b0;
	localparam logic [OP_W-1:0] OP_QUERY = 1'b1;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} state_t;

endpackage

// ===== src/bsnp_if.sv =====
// Handshake interfaces for the command and response channels.
// Depends on bsnp_pkg for the field widths and default coordinate width.

interface bsnp_cmd_if #(
	parameter int COORD_BITS = bsnp_pkg::DEF_COORD_BITS
);
	logic                             valid;
	logic                             ready;
	logic [bsnp_pkg::OP_W-1:0]        operation;
	logic [bsnp_pkg::SLOT_W-1:0]      slot;
	logic signed [COORD_BITS-1:0]     lo_x;
	logic signed [COORD_BITS-1:0]     lo_y;
	logic signed [COORD_BITS-1:0]     lo_z;
	logic signed [COORD_BITS-1:0]     hi_x;
	logic signed [COORD_BITS-1:0]     hi_y;
	logic signed [COORD_BITS-1:0]     hi_z;
	logic signed [COORD_BITS-1:0]     point_x;
	logic signed [COORD_BITS-1:0]     point_y;
	logic signed [COORD_BITS-1:0]     point_z;

	modport source (
		output valid, operation, slot, lo_x, lo_y, lo_z, hi_x, hi_y, hi_z,
		       point_x, point_y, point_z,
		input  ready
	);
	modport sink (
		input  valid, operation, slot, lo_x, lo_y, lo_z, hi_x, hi_y, hi_z,
		       point_x, point_y, point_z,
		output ready
	);
endinterface

interface bsnp_rsp_if #(
	parameter int COORD_BITS = bsnp_pkg::DEF_COORD_BITS
);
	logic                              valid;
	logic                              ready;
	logic                              inside_res;
	logic                              found;
	logic [bsnp_pkg::BOX_INDEX_W-1:0]  box_index;
	logic signed [COORD_BITS-1:0]      out_x;
	logic signed [COORD_BITS-1:0]      out_y;
	logic signed [COORD_BITS-1:0]      out_z;

	modport source (
		output valid, inside_res, found, box_index, out_x, out_y, out_z,
		input  ready
	);
	modport sink (
		input  valid, inside_res, found, box_index, out_x, out_y, out_z,
		output ready
	);
endinterface

// ===== src/box_set_nearest_point_clamp.sv =====
// Top level of the box set nearest point clamp block: box table, query pipeline and APB port.
// Depends on bsnp_pkg and on the bsnp_cmd_if / bsnp_rsp_if interfaces.
//
// The block keeps a table of MAX_BOXES axis-aligned boxes in one synchronous memory. A load
// transaction writes one box into a slot and answers with an all-zero response; a load to a
// slot at or above MAX_BOXES is dropped but still answered. A query transaction reads the
// first active_box_count slots (capped at MAX_BOXES), one slot per cycle through the single
// read port of the table, clamps the point into each box and keeps the clamp with the
// smallest squared distance, the lower slot winning ties. A box that holds the point gives
// distance zero, so the first such box wins and the point comes back unchanged with
// inside_res set. With no active box the point comes back unchanged and found is low.
// With at least one active box, a query is answered once every box has been read, the last
// box has been clamped, squared, summed and compared, the sequencer has left the run state
// and the response register has been loaded. A query with no active box finds nothing to
// read and leaves the run state, and a load skips it and goes straight to the response.
// One command is in progress at a time; a new command is accepted while the
// previous response still waits on the response channel.
// Slots never loaded since reset hold unknown data and must not be queried.
// active_box_count lives at byte address 0 of the APB port; writes should happen only while
// the block is idle. Coordinates are signed two's complement, COORD_BITS wide (Q16.8 at 24).
module box_set_nearest_point_clamp #(
	parameter int MAX_BOXES  = bsnp_pkg::DEF_MAX_BOXES,
	parameter int COORD_BITS = bsnp_pkg::DEF_COORD_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	bsnp_cmd_if.sink                            cmd,
	bsnp_rsp_if.source                          rsp,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [bsnp_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [bsnp_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [bsnp_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                pready
);
	import bsnp_pkg::*;

	localparam int CB    = COORD_BITS;
	localparam int IDX_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
	localparam int CNT_W = $clog2(MAX_BOXES + 1);
	localparam int NW    = (CNT_W > CFG_W) ? CNT_W : CFG_W;
	localparam int SQ_W  = 2 * CB;
	localparam int DST_W = SQ_W + 2;
	localparam int WORD_W = 6 * CB;

	// ------------------------------------------------------------------
	// Configuration register
	// ------------------------------------------------------------------
	logic [CFG_W-1:0] box_count_q;
	logic             cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_ACTIVE_BOX_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_count_q <= '0;
		end else if (cfg_wr) begin
			box_count_q <= pwdata[CFG_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr == ADDR_ACTIVE_BOX_COUNT) begin
			prdata = APB_DATA_W'(box_count_q);
		end
	end

	// ------------------------------------------------------------------
	// Command acceptance and sequencer
	// ------------------------------------------------------------------
	state_t state_q, state_d;
	logic   cmd_acc;
	logic   is_query;
	logic   run_done;
	logic   rsp_free;
	logic   rsp_load;

	logic [NW-1:0] n_lim;
	logic [NW-1:0] n_q;
	logic [NW-1:0] iss_q;
	logic          issue;

	logic v_s1, v_s2, v_s3, v_s4;

	assign cmd.ready = (state_q == ST_IDLE);
	assign cmd_acc   = cmd.valid && cmd.ready;
	assign is_query  = (cmd.operation == OP_QUERY);
	assign rsp_free  = !rsp.valid || rsp.ready;
	assign issue     = (state_q == ST_RUN) && (iss_q < n_q);
	assign run_done  = (iss_q >= n_q) && !v_s1 && !v_s2 && !v_s3 && !v_s4;

	always_comb begin
		if (NW'(box_count_q) > NW'(MAX_BOXES)) begin
			n_lim = NW'(MAX_BOXES);
		end else begin
			n_lim = NW'(box_count_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		rsp_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (cmd_acc) begin
					state_d = is_query ? ST_RUN : ST_DONE;
				end
			end
			ST_RUN: begin
				if (run_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (rsp_free) begin
					rsp_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Issue counter and stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_q <= '0;
			n_q   <= '0;
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
		end else begin
			if (cmd_acc) begin
				iss_q <= '0;
				n_q   <= is_query ? n_lim : '0;
			end else if (issue) begin
				iss_q <= iss_q + 1'b1;
			end
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// ------------------------------------------------------------------
	// Box table: one write port for loads, one registered read port for queries
	// ------------------------------------------------------------------
	logic [WORD_W-1:0] box_mem [MAX_BOXES];
	logic [WORD_W-1:0] rd_word_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic              slot_ok;

	assign slot_ok = (int'(cmd.slot) < MAX_BOXES);

	always_ff @(posedge clk) begin
		if (cmd_acc && !is_query && slot_ok) begin
			box_mem[IDX_W'(cmd.slot)] <= {cmd.hi_z, cmd.hi_y, cmd.hi_x,
			                              cmd.lo_z, cmd.lo_y, cmd.lo_x};
		end
		if (issue) begin
			rd_word_s1 <= box_mem[iss_q[IDX_W-1:0]];
			idx_s1     <= iss_q[IDX_W-1:0];
		end
	end

	// ------------------------------------------------------------------
	// Query pipeline
	// ------------------------------------------------------------------
	logic signed [CB-1:0] p_q [3];

	// Stage 1: clamp each axis and take the distance magnitude.
	logic signed [CB-1:0] c_d [3];
	logic [CB-1:0]        d_d [3];

	always_comb begin
		logic signed [CB-1:0] lo;
		logic signed [CB-1:0] hi;
		logic signed [CB:0]   below;
		logic signed [CB:0]   above;
		for (int a = 0; a < 3; a++) begin
			lo    = rd_word_s1[a*CB +: CB];
			hi    = rd_word_s1[(a+3)*CB +: CB];
			below = {lo[CB-1], lo} - {p_q[a][CB-1], p_q[a]};
			above = {p_q[a][CB-1], p_q[a]} - {hi[CB-1], hi};
			if (p_q[a] < lo) begin
				c_d[a] = lo;
				d_d[a] = below[CB-1:0];
			end else if (p_q[a] > hi) begin
				c_d[a] = hi;
				d_d[a] = above[CB-1:0];
			end else begin
				c_d[a] = p_q[a];
				d_d[a] = '0;
			end
		end
	end

	logic signed [CB-1:0] c_s2 [3];
	logic [CB-1:0]        d_s2 [3];
	logic [IDX_W-1:0]     idx_s2;
	logic signed [CB-1:0] c_s3 [3];
	logic [SQ_W-1:0]      sq_s3 [3];
	logic [IDX_W-1:0]     idx_s3;
	logic signed [CB-1:0] c_s4 [3];
	logic [DST_W-1:0]     dist_s4;
	logic [IDX_W-1:0]     idx_s4;

	// Stage 2 squares the magnitudes, stage 3 sums them.
	always_ff @(posedge clk) begin
		for (int a = 0; a < 3; a++) begin
			c_s2[a]  <= c_d[a];
			d_s2[a]  <= d_d[a];
			c_s3[a]  <= c_s2[a];
			sq_s3[a] <= SQ_W'(d_s2[a]) * SQ_W'(d_s2[a]);
			c_s4[a]  <= c_s3[a];
		end
		idx_s2  <= idx_s1;
		idx_s3  <= idx_s2;
		idx_s4  <= idx_s3;
		dist_s4 <= DST_W'(sq_s3[0]) + DST_W'(sq_s3[1]) + DST_W'(sq_s3[2]);
	end

	// Stage 4: keep the nearest clamp; strict compare lets the lower slot win ties.
	logic [DST_W-1:0]     best_dist_q;
	logic signed [CB-1:0] best_c_q [3];
	logic [IDX_W-1:0]     best_idx_q;
	logic                 have_q;
	logic                 is_query_q;
	logic                 take;

	assign take = v_s4 && (!have_q || (dist_s4 < best_dist_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q     <= 1'b0;
			is_query_q <= 1'b0;
		end else if (cmd_acc) begin
			have_q     <= 1'b0;
			is_query_q <= is_query;
		end else if (take) begin
			have_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			p_q[0]      <= cmd.point_x;
			p_q[1]      <= cmd.point_y;
			p_q[2]      <= cmd.point_z;
			best_c_q[0] <= cmd.point_x;
			best_c_q[1] <= cmd.point_y;
			best_c_q[2] <= cmd.point_z;
			best_idx_q  <= '0;
			best_dist_q <= '0;
		end else if (take) begin
			best_c_q    <= c_s4;
			best_idx_q  <= idx_s4;
			best_dist_q <= dist_s4;
		end
	end

	// ------------------------------------------------------------------
	// Response register
	// ------------------------------------------------------------------
	logic rsp_valid_q;

	assign rsp.valid = rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// A load answers with every field zero.
	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp.inside_res <= is_query_q && have_q && (best_dist_q == '0);
			rsp.found      <= is_query_q && have_q;
			rsp.box_index  <= is_query_q ? BOX_INDEX_W'(best_idx_q) : '0;
			rsp.out_x      <= is_query_q ? best_c_q[0] : '0;
			rsp.out_y      <= is_query_q ? best_c_q[1] : '0;
			rsp.out_z      <= is_query_q ? best_c_q[2] : '0;
		end
	end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for box_set_nearest_point_clamp: drives load and query transactions and
// checks every response against a predictor kept inside this file or a value typed in by hand.
// Depends on bsnp_pkg, the bsnp_cmd_if / bsnp_rsp_if interfaces and the block itself.

module tb_top;
	import bsnp_pkg::*;

	localparam int COORD_W     = DEF_COORD_BITS;
	localparam int NUM_SLOTS   = DEF_MAX_BOXES;
	localparam int CYCLE_LIMIT = 200000;
	localparam int TAIL_CYCLES = 40;    // well above one full 16-box query plus the pipeline
	localparam int HOLD_AT     = 150;   // response count at which the receiver holds off
	localparam int HOLD_LEN    = 400;   // length of that hold in cycles
	localparam int PHASE_ITEMS = 90;

	localparam int C_MIN = -(1 << (COORD_W - 1));
	localparam int C_MAX = (1 << (COORD_W - 1)) - 1;

	typedef logic signed [COORD_W-1:0] coord_t;

	// One command transaction; index 0, 1, 2 of each array is x, y, z.
	typedef struct {
		logic [OP_W-1:0]   op;
		logic [SLOT_W-1:0] slot;
		coord_t            lo [3];
		coord_t            hi [3];
		coord_t            pt [3];
	} cmd_t;

	// One response transaction.
	typedef struct {
		logic                   in_box;
		logic                   found;
		logic [BOX_INDEX_W-1:0] idx;
		coord_t                 pos [3];
	} result_t;

	// A row of the directed table. A negative box_cnt leaves the register alone;
	// otherwise the register is written, once the block has gone quiet, before the row.
	typedef struct {
		int      box_cnt;
		cmd_t    cmd;
		bit      typed;
		result_t want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;

	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	bsnp_cmd_if #(.COORD_BITS(COORD_W)) cmd_ch ();
	bsnp_rsp_if #(.COORD_BITS(COORD_W)) rsp_ch ();

	box_set_nearest_point_clamp #(
		.MAX_BOXES  (NUM_SLOTS),
		.COORD_BITS (COORD_W)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Predictor state: our own copy of the box table and of the box count register.
	coord_t     slot_min [NUM_SLOTS][3];
	coord_t     slot_max [NUM_SLOTS][3];
	logic [4:0] box_count;

	// Results still owed by the block, oldest first.
	result_t pending_results [$];

	// Directed stimulus table.
	dir_row_t dir_rows [$];

	int  err_cnt   = 0;
	int  rsp_seen  = 0;
	int  cycle_cnt = 0;
	bit  no_idle   = 1'b0;   // when set, neither side inserts gaps or stalls
	bit  held_once = 1'b0;

	always #2 clk = ~clk;

	// Watchdog. A hang anywhere (a lost response, a stuck ready) ends up here.
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Prints one line per mismatch and counts it.
	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("[%0t] MISMATCH %s: got %0d expected %0d", $time, what, got, want);
		err_cnt++;
	endtask

	// Appends one row to the directed table.
	function automatic void add_row(input int cnt, input cmd_t c, input bit typed,
	                                input result_t want);
		dir_row_t row;
		row.box_cnt = cnt;
		row.cmd     = c;
		row.typed   = typed;
		row.want    = want;
		dir_rows.insert(dir_rows.size(), row);
	endfunction

	// Predictor. A load updates our table and is answered with an all-zero response.
	// A query walks the first box_count slots (capped at the table size). The first box
	// that holds the point on all three axes, bounds included, wins outright. Otherwise
	// every box contributes its clamp of the point, and the strictly smaller squared
	// distance replaces the best so far, so the lower slot keeps a tie. Inverted boxes
	// need no special handling: the below-min test comes first, then the above-max test.
	function automatic result_t nearest_box_result(input cmd_t c);
		result_t r;
		coord_t  clamp_pt [3];
		coord_t  best_pt [3];
		longint  sq_dist;
		longint  best_dist;
		longint  d;
		int      n;
		bit      have;
		bit      moved;
		r.in_box = 1'b0;
		r.found  = 1'b0;
		r.idx    = '0;
		r.pos    = '{default: '0};
		if (c.op == OP_LOAD) begin
			slot_min[c.slot] = c.lo;
			slot_max[c.slot] = c.hi;
			return r;
		end
		n         = (box_count > NUM_SLOTS) ? NUM_SLOTS : int'(box_count);
		best_pt   = c.pt;
		best_dist = 0;
		have      = 1'b0;
		for (int i = 0; i < n; i++) begin
			moved   = 1'b0;
			sq_dist = 0;
			for (int a = 0; a < 3; a++) begin
				if (c.pt[a] < slot_min[i][a]) begin
					clamp_pt[a] = slot_min[i][a];
					moved = 1'b1;
				end else if (c.pt[a] > slot_max[i][a]) begin
					clamp_pt[a] = slot_max[i][a];
					moved = 1'b1;
				end else begin
					clamp_pt[a] = c.pt[a];
				end
				d = longint'(c.pt[a]) - longint'(clamp_pt[a]);
				sq_dist += d * d;
			end
			if (!moved) begin
				r.in_box = 1'b1;
				r.found  = 1'b1;
				r.idx    = BOX_INDEX_W'(i);
				r.pos    = c.pt;
				return r;
			end
			if (!have || sq_dist < best_dist) begin
				have      = 1'b1;
				best_dist = sq_dist;
				r.idx     = BOX_INDEX_W'(i);
				best_pt   = clamp_pt;
			end
		end
		r.found = have;
		r.pos   = best_pt;
		return r;
	endfunction

	function automatic cmd_t mk_load(input int s, input int lx, input int ly, input int lz,
	                                 input int hx, input int hy, input int hz);
		cmd_t c;
		c.op   = OP_LOAD;
		c.slot = SLOT_W'(s);
		c.lo   = '{coord_t'(lx), coord_t'(ly), coord_t'(lz)};
		c.hi   = '{coord_t'(hx), coord_t'(hy), coord_t'(hz)};
		c.pt   = '{default: '0};
		return c;
	endfunction

	function automatic cmd_t mk_query(input int px, input int py, input int pz);
		cmd_t c;
		c.op   = OP_QUERY;
		c.slot = '0;
		c.lo   = '{default: '0};
		c.hi   = '{default: '0};
		c.pt   = '{coord_t'(px), coord_t'(py), coord_t'(pz)};
		return c;
	endfunction

	function automatic result_t mk_res(input bit ib, input bit fnd, input int idx,
	                                   input int x, input int y, input int z);
		result_t r;
		r.in_box = ib;
		r.found  = fnd;
		r.idx    = BOX_INDEX_W'(idx);
		r.pos    = '{coord_t'(x), coord_t'(y), coord_t'(z)};
		return r;
	endfunction

	// Random coordinates. Three in eight land in a small region around the origin so that boxes
	// and points overlap often; the rest cover the full range and its extremes.
	function automatic coord_t region_coord();
		return coord_t'(int'($urandom_range(0, 16383)) - 8192);
	endfunction

	function automatic coord_t any_coord();
		int unsigned pick;
		pick = $urandom_range(0, 7);
		if (pick == 0) begin
			case ($urandom_range(0, 3))
				0:       return coord_t'(C_MIN);
				1:       return coord_t'(C_MAX);
				2:       return '0;
				default: return '1;
			endcase
		end
		if (pick <= 3)
			return region_coord();
		return coord_t'($urandom);
	endfunction

	// A coordinate inside or just outside the span [lo, hi] of one axis of a box.
	function automatic coord_t near_coord(input coord_t lo, input coord_t hi);
		int margin;
		margin = $urandom_range(0, 600);
		if (lo > hi)
			return coord_t'(int'(($urandom_range(0, 1) != 0) ? lo : hi)
			                + int'($urandom_range(0, 2 * margin)) - margin);
		return coord_t'(int'(lo) - margin
		                + int'($urandom_range(0, int'(hi) - int'(lo) + 2 * margin)));
	endfunction

	// Random transaction. Every field is randomized first so unused fields toggle too,
	// then the fields that matter are shaped for the operation.
	function automatic cmd_t random_item();
		cmd_t        c;
		int          n;
		int          k;
		int unsigned style;
		c.op   = ($urandom_range(0, 3) == 0) ? OP_LOAD : OP_QUERY;
		c.slot = SLOT_W'($urandom_range(0, NUM_SLOTS - 1));
		for (int a = 0; a < 3; a++) begin
			c.lo[a] = any_coord();
			c.hi[a] = any_coord();
			c.pt[a] = any_coord();
		end
		if (c.op == OP_LOAD) begin
			style = $urandom_range(0, 9);
			if (style == 9) begin
				// Duplicate an existing box so that equal distances come up.
				k    = $urandom_range(0, NUM_SLOTS - 1);
				c.lo = slot_min[k];
				c.hi = slot_max[k];
			end else begin
				for (int a = 0; a < 3; a++) begin
					style = $urandom_range(0, 9);
					if (style < 7) begin
						c.lo[a] = region_coord();
						c.hi[a] = coord_t'(int'(c.lo[a]) + int'($urandom_range(0, 3000)));
					end else if (style == 7) begin
						// Inverted on this axis.
						c.lo[a] = region_coord();
						c.hi[a] = coord_t'(int'(c.lo[a]) - int'($urandom_range(1, 3000)));
					end
				end
			end
		end else begin
			n     = (box_count > NUM_SLOTS) ? NUM_SLOTS : int'(box_count);
			style = $urandom_range(0, 9);
			if (style < 5 && n > 0) begin
				k = $urandom_range(0, n - 1);
				for (int a = 0; a < 3; a++)
					c.pt[a] = near_coord(slot_min[k][a], slot_max[k][a]);
			end else if (style < 8) begin
				for (int a = 0; a < 3; a++)
					c.pt[a] = region_coord();
			end
		end
		return c;
	endfunction

	// Offers one command transaction after a random gap (none while no_idle is set) and records
	// what it should produce. The handshake is looked at on the falling edge, where every signal
	// is settled, and the transaction completes on the rising edge that follows.
	task automatic send_item(input cmd_t c, input bit typed, input result_t want);
		result_t predicted;
		int      gap;
		gap = no_idle ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid     <= 1'b1;
		cmd_ch.operation <= c.op;
		cmd_ch.slot      <= c.slot;
		cmd_ch.lo_x      <= c.lo[0];
		cmd_ch.lo_y      <= c.lo[1];
		cmd_ch.lo_z      <= c.lo[2];
		cmd_ch.hi_x      <= c.hi[0];
		cmd_ch.hi_y      <= c.hi[1];
		cmd_ch.hi_z      <= c.hi[2];
		cmd_ch.point_x   <= c.pt[0];
		cmd_ch.point_y   <= c.pt[1];
		cmd_ch.point_z   <= c.pt[2];
		@(negedge clk);
		while (cmd_ch.ready !== 1'b1) @(negedge clk);
		// The predictor runs for every row so its table stays in step with the block,
		// even where the directed table types the expected response in by hand.
		predicted = nearest_box_result(c);
		pending_results.insert(pending_results.size(), typed ? want : predicted);
		@(posedge clk);
	endtask

	// Lets the block run dry: no command offered and nothing left owed.
	task automatic wait_idle();
		cmd_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	// Writes the box count register over APB, then reads it back.
	task automatic set_box_count(input int unsigned value);
		logic [APB_DATA_W-1:0] rd;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_ACTIVE_BOX_COUNT;
		pwdata  <= APB_DATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		while (pready !== 1'b1) @(negedge clk);
		@(posedge clk);
		box_count = value[4:0];
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		while (pready !== 1'b1) @(negedge clk);
		rd = prdata;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (rd !== APB_DATA_W'(value[4:0]))
			report_mismatch("active_box_count readback", rd, value[4:0]);
	endtask

	// Compares one response transaction with the oldest expectation, field by field.
	task automatic check_response();
		result_t want;
		rsp_seen++;
		if (pending_results.size() == 0) begin
			report_mismatch("response with nothing outstanding", rsp_seen, 0);
			return;
		end
		want = pending_results.pop_front();
		if (rsp_ch.inside_res !== want.in_box)
			report_mismatch("inside_res", rsp_ch.inside_res, want.in_box);
		if (rsp_ch.found !== want.found)
			report_mismatch("found", rsp_ch.found, want.found);
		if (rsp_ch.box_index !== want.idx)
			report_mismatch("box_index", rsp_ch.box_index, want.idx);
		if (rsp_ch.out_x !== want.pos[0])
			report_mismatch("out_x", rsp_ch.out_x, want.pos[0]);
		if (rsp_ch.out_y !== want.pos[1])
			report_mismatch("out_y", rsp_ch.out_y, want.pos[1]);
		if (rsp_ch.out_z !== want.pos[2])
			report_mismatch("out_z", rsp_ch.out_z, want.pos[2]);
	endtask

	// Response side. Ready drops for a random number of cycles before each transaction.
	// Once, after HOLD_AT responses, it is held off while the command side keeps offering,
	// so the block fills up and has to push back on its input.
	initial begin : rsp_side
		int stall;
		rsp_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 6);
			if (!held_once && rsp_seen >= HOLD_AT) begin
				held_once = 1'b1;
				stall     = HOLD_LEN;
			end
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			@(negedge clk);
			while (rsp_ch.valid !== 1'b1) @(negedge clk);
			check_response();
			@(posedge clk);
		end
	end

	// Command side and the run itself.
	initial begin : stimulus
		result_t  load_ack;
		int       phase_count [6];

		arst_n           = 1'b0;
		psel             = 1'b0;
		penable          = 1'b0;
		pwrite           = 1'b0;
		paddr            = '0;
		pwdata           = '0;
		cmd_ch.valid     = 1'b0;
		cmd_ch.operation = OP_LOAD;
		cmd_ch.slot      = '0;
		cmd_ch.lo_x      = '0;
		cmd_ch.lo_y      = '0;
		cmd_ch.lo_z      = '0;
		cmd_ch.hi_x      = '0;
		cmd_ch.hi_y      = '0;
		cmd_ch.hi_z      = '0;
		cmd_ch.point_x   = '0;
		cmd_ch.point_y   = '0;
		cmd_ch.point_z   = '0;
		box_count        = '0;
		slot_min         = '{default: '{default: '0}};
		slot_max         = '{default: '{default: '0}};
		load_ack         = mk_res(0, 0, 0, 0, 0, 0);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table. Right after reset the count is zero, so the first query sees
		// no box and must come back untouched with found low. All sixteen slots are then
		// loaded before any query can reach them, since a slot never written since reset
		// holds unknown data. The rows cover the full-range box, a box pinned to each
		// end of the coordinate range, an inverted box, a single-point box, two equal
		// boxes for the tie rule, and count values of one, three, the table size and above it.
		add_row(-1, mk_query(C_MAX, C_MIN, 0), 1'b1, mk_res(0, 0, 0, C_MAX, C_MIN, 0));
		add_row(-1, mk_load(0, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX), 1'b1, load_ack);
		add_row(-1, mk_load(1, 0, 0, 0, 256, 256, 256), 1'b1, load_ack);
		add_row(-1, mk_load(2, 100, -50, -50, -100, 50, 50), 1'b1, load_ack);
		add_row(-1, mk_load(3, 5, 5, 5, 5, 5, 5), 1'b1, load_ack);
		add_row(-1, mk_load(4, 1000, 1000, 1000, 2000, 2000, 2000), 1'b1, load_ack);
		add_row(-1, mk_load(5, 1000, 1000, 1000, 2000, 2000, 2000), 1'b1, load_ack);
		add_row(-1, mk_load(6, -3000, -3000, -3000, -2000, -1000, -2500), 1'b1, load_ack);
		add_row(-1, mk_load(7, C_MAX - 255, C_MAX - 255, C_MAX - 255,
		                    C_MAX, C_MAX, C_MAX), 1'b1, load_ack);
		add_row(-1, mk_load(8, C_MIN, C_MIN, C_MIN,
		                    C_MIN + 255, C_MIN + 255, C_MIN + 255), 1'b1, load_ack);
		for (int s = 9; s < NUM_SLOTS; s++)
			add_row(-1, mk_load(s, s * 600, -s * 400, 300,
			                    s * 600 + 200, -s * 400 + 100, 350), 1'b1, load_ack);
		// Slot 0 spans everything, so with one box active every point is inside it.
		add_row(1, mk_query(C_MAX, C_MAX, C_MAX), 1'b1,
		        mk_res(1, 1, 0, C_MAX, C_MAX, C_MAX));
		add_row(-1, mk_query(C_MIN, C_MIN, C_MIN), 1'b1,
		        mk_res(1, 1, 0, C_MIN, C_MIN, C_MIN));
		add_row(-1, mk_load(0, 10000, 10000, 10000, 12000, 12000, 12000), 1'b1, load_ack);
		// A count above the table size behaves as the table size.
		add_row(31, mk_query(C_MAX, C_MAX, C_MAX), 1'b0, load_ack);
		add_row(-1, mk_query(10, 20, 30), 1'b0, load_ack);
		// Outside both equal boxes: the lower slot has to win.
		add_row(-1, mk_query(1500, 1500, 3000), 1'b0, load_ack);
		add_row(16, mk_query(-150, 0, 0), 1'b0, load_ack);
		add_row(-1, mk_query(0, 0, 200), 1'b0, load_ack);
		add_row(3, mk_query(-150, 70, -70), 1'b0, load_ack);
		add_row(17, mk_query(C_MIN, C_MAX, C_MIN), 1'b0, load_ack);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].box_cnt >= 0) begin
				wait_idle();
				set_box_count(dir_rows[i].box_cnt);
			end
			send_item(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].want);
		end

		// Random phases, each with its own box count: the full table, none, the largest
		// register value, a few boxes, a single box and one count drawn at random. One
		// phase runs with no gaps on either side.
		phase_count = '{16, 0, 31, 5, 1, $urandom_range(2, 15)};
		foreach (phase_count[ph]) begin
			wait_idle();
			set_box_count(phase_count[ph]);
			no_idle = (ph == 3);
			repeat (PHASE_ITEMS) send_item(random_item(), 1'b0, load_ack);
		end
		no_idle = 1'b0;

		wait_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_results.size() != 0)
			report_mismatch("responses never delivered", pending_results.size(), 0);

		if (err_cnt == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
